/* design/lprt_pkg.sv */
package lprt_pkg;
	localparam int TableDepth = 64;
	localparam int CntW = $clog2(TableDepth + 1);

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_REMOVE  = 2'd1,
		OP_MATCH   = 2'd2,
		OP_ITERATE = 2'd3
	} op_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] addr;
		logic [5:0]  len;
		logic [15:0] port;
	} entry_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] addr;
		logic [5:0]  len;
		logic        exact;
		logic [15:0] port;
	} req_t;

	// per-cell flags, chained to the neighbors
	typedef struct packed {
		logic ins_here;   // insert at or before this cell
		logic del_here;   // this cell or an earlier one is removed
		logic hit;        // this cell matches the request
		logic prev_hit;   // previous cell matches (iterate successor); the cell drives it low
	} cell_flags_t;

	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) m = 32'd0;
		else if (len >= 6'd32) m = '1;
		else m = ~(32'hFFFF_FFFF >> len);
		return m;
	endfunction
endpackage

/* design/lprt_cell.sv */
module lprt_cell import lprt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        update,
	input  req_t        req,
	input  logic        ins_prev,
	input  logic        del_prev,
	input  logic        del_this,
	input  entry_t      left,
	input  entry_t      right,
	input  entry_t      right2,
	input  logic        del_right,
	output entry_t      cur,
	output logic        ins_out,
	output cell_flags_t flags
);
	entry_t e_q;
	logic   valid_q;
	logic   here;

	assign cur = '{valid: valid_q, addr: e_q.addr, len: e_q.len, port: e_q.port};

	// insert position: first cell that is empty or shorter
	assign here = !valid_q || (e_q.len < req.len);
	assign ins_out = ins_prev || here;

	always_comb begin
		flags.ins_here = ins_out;
		flags.del_here = del_prev || del_this;
		flags.prev_hit = 1'b0;
		case (req.op)
			OP_MATCH: begin
				if (req.exact)
					flags.hit = valid_q && e_q.addr == req.addr && e_q.len == req.len;
				else
					flags.hit = valid_q && ((req.addr & prefix_mask(e_q.len)) == e_q.addr);
			end
			OP_ITERATE: flags.hit = valid_q && e_q.port == req.port;
			default: flags.hit = valid_q && e_q.addr == req.addr && e_q.len == req.len;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (update) begin
			if (req.op == OP_INSERT) begin
				if (ins_prev) valid_q <= left.valid;
				else if (here) valid_q <= 1'b1;
			end else if (req.op == OP_REMOVE && del_this) begin
				valid_q <= del_right ? right2.valid : right.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			if (req.op == OP_INSERT) begin
				if (ins_prev) e_q <= left;
				else if (here) e_q <= '{valid: 1'b1, addr: req.addr, len: req.len,
					port: req.port};
			end else if (req.op == OP_REMOVE && del_this) begin
				e_q <= del_right ? right2 : right;
			end
		end
	end
endmodule

/* design/longest_prefix_route_table.sv */
// Match, iterate and insert: the request is registered on start, then result and strobe are registered.
// Remove first deletes the matching routes one at a time (one-step compaction each), then strobes.
// A new request is taken only while busy is low, so one request is finished before the next starts.
// Reset: arst_n clears all valid bits and the route count; no clearing pass.
// The receiver cannot stall: results show for one cycle under strobe.
module longest_prefix_route_table import lprt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] ip_addr,
	input  logic [5:0]  prefix_len,
	input  logic        exact_mode,
	input  logic [15:0] route_index,
	output logic        strobe,
	output logic [15:0] result_index,
	output logic        hit,
	output logic        rejected
);
	localparam int N = TableDepth;

	req_t        req_q;
	logic        act_q, rm_hit_q;
	logic [CntW-1:0] count_q;
	entry_t      cells [N];
	cell_flags_t fl [N];
	logic        ins_c [N+1];
	logic        del_c [N+1];
	logic        dthis [N];
	logic        upd;
	logic [N-1:0] hitv;
	logic        anyhit;
	logic        full;
	entry_t      empty_e;

	assign empty_e = '{valid: 1'b0, addr: '0, len: '0, port: '0};
	assign busy = act_q;
	assign full = count_q >= CntW'(N);
	assign ins_c[0] = 1'b0;
	assign del_c[0] = 1'b0;

	// remove: one matching cell deleted per cycle (first one), rest shift left
	always_comb begin
		for (int i = 0; i < N; i++) hitv[i] = fl[i].hit;
		anyhit = |hitv;
	end

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			entry_t l, r, r2;
			logic   dr;
			if (g == 0) begin : g_l0
				assign l = empty_e;
			end else begin : g_l
				assign l = cells[g-1];
			end
			if (g < N - 1) begin : g_r
				assign r = cells[g+1];
			end else begin : g_r0
				assign r = empty_e;
			end
			assign r2 = r;
			assign dr = 1'b0;
			assign dthis[g] = del_c[g] || (fl[g].hit && !del_c[g]);
			assign del_c[g+1] = dthis[g];
			lprt_cell u_cell (
				.clk(clk), .arst_n(arst_n), .update(upd), .req(req_q),
				.ins_prev(ins_c[g]), .del_prev(del_c[g]), .del_this(dthis[g]),
				.left(l), .right(r), .right2(r2), .del_right(dr),
				.cur(cells[g]), .ins_out(ins_c[g+1]), .flags(fl[g])
			);
		end
	endgenerate

	logic [15:0] sel_port;
	logic        sel_hit;
	always_comb begin
		sel_port = '0;
		sel_hit = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			if (req_q.op == OP_ITERATE) begin
				if (req_q.port == 16'd0) begin
					if (i == 0 && cells[0].valid) begin
						sel_hit = 1'b1;
						sel_port = cells[0].port;
					end
				end else if (i < N - 1 && fl[i].hit && cells[i+1].valid) begin
					sel_hit = 1'b1;
					sel_port = cells[i+1].port;
				end else if (fl[i].hit) begin
					sel_hit = 1'b0;
					sel_port = '0;
				end
			end else if (fl[i].hit) begin
				sel_hit = 1'b1;
				sel_port = cells[i].port;
			end
		end
	end

	always_comb begin
		upd = 1'b0;
		if (act_q) begin
			case (req_q.op)
				OP_INSERT: upd = !full;
				OP_REMOVE: upd = anyhit;
				default:   upd = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			rm_hit_q <= 1'b0;
			count_q <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (start && !act_q) begin
				act_q <= 1'b1;
				rm_hit_q <= 1'b0;
			end else if (act_q) begin
				if (req_q.op == OP_REMOVE && anyhit) begin
					rm_hit_q <= 1'b1;
					count_q <= count_q - CntW'(1);
				end else begin
					act_q <= 1'b0;
					strobe <= 1'b1;
					if (req_q.op == OP_INSERT && !full) count_q <= count_q + CntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !act_q) begin
			req_q <= '{op: op_t'(opcode), addr: ip_addr, len: prefix_len,
				exact: exact_mode, port: route_index};
		end
		if (act_q && !(req_q.op == OP_REMOVE && anyhit)) begin
			result_index <= '0;
			hit <= 1'b0;
			rejected <= 1'b0;
			case (req_q.op)
				OP_INSERT: rejected <= full;
				OP_REMOVE: hit <= rm_hit_q;
				default: begin
					hit <= sel_hit;
					result_index <= sel_port;
				end
			endcase
		end
	end
endmodule

/* design/lprt_checker.sv */
module lprt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic [15:0] result_index,
	input logic        hit,
	input logic        rejected
);
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");
	a_strobe_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy) else $error("strobe while busy");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !hit |-> result_index == 16'd0) else $error("miss with index");
	a_rej_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && rejected |-> !hit) else $error("reject with hit");
endmodule

bind longest_prefix_route_table lprt_checker u_lprt_checker (.*);

/* tb/testbench.sv */
module testbench;
	import lprt_pkg::*;

	localparam int WatchLimit = 2000;

	class route_scoreboard;
		logic [31:0] addr_q[$];
		logic [5:0]  len_q[$];
		logic [15:0] port_q[$];
		logic [15:0] exp_index[$];
		logic        exp_hit[$];
		logic        exp_rej[$];
		int          errors;
		int          checked;

		function void note_request(op_t op, logic [31:0] addr, logic [5:0] len,
				logic exact, logic [15:0] port);
			logic [15:0] res;
			logic        h;
			logic        rj;
			int          pos;
			res = '0;
			h = 1'b0;
			rj = 1'b0;
			case (op)
				OP_INSERT: begin
					if (addr_q.size() >= TableDepth) begin
						rj = 1'b1;
					end else begin
						pos = 0;
						while (pos < len_q.size() && len_q[pos] >= len) pos++;
						addr_q.insert(pos, addr);
						len_q.insert(pos, len);
						port_q.insert(pos, port);
					end
				end
				OP_REMOVE: begin
					for (int i = addr_q.size() - 1; i >= 0; i--) begin
						if (addr_q[i] == addr && len_q[i] == len) begin
							h = 1'b1;
							addr_q.delete(i);
							len_q.delete(i);
							port_q.delete(i);
						end
					end
				end
				OP_MATCH: begin
					for (int i = 0; i < addr_q.size(); i++) begin
						if (exact ? (addr_q[i] == addr && len_q[i] == len)
								: ((addr & lpm_mask(len_q[i])) == addr_q[i])) begin
							h = 1'b1;
							res = port_q[i];
							break;
						end
					end
				end
				default: begin
					pos = 0;
					if (port != 0) begin
						pos = port_q.size();
						for (int i = 0; i < port_q.size(); i++) begin
							if (port_q[i] == port) begin
								pos = i + 1;
								break;
							end
						end
					end
					if (pos < port_q.size()) begin
						h = 1'b1;
						res = port_q[pos];
					end
				end
			endcase
			exp_index = {exp_index, res};
			exp_hit = {exp_hit, h};
			exp_rej = {exp_rej, rj};
		endfunction

		function logic [31:0] lpm_mask(logic [5:0] len);
			if (len == 0) return 32'd0;
			if (len >= 32) return 32'hFFFF_FFFF;
			return 32'hFFFF_FFFF << (32 - len);
		endfunction

		function void check_result(logic [15:0] idx, logic h, logic rj);
			if (exp_index.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
				return;
			end
			checked++;
			if (idx !== exp_index[0]) begin
				$error("result_index expected %0d actual %0d", exp_index[0], idx);
				errors++;
			end
			if (h !== exp_hit[0]) begin
				$error("hit expected %0b actual %0b", exp_hit[0], h);
				errors++;
			end
			if (rj !== exp_rej[0]) begin
				$error("rejected expected %0b actual %0b", exp_rej[0], rj);
				errors++;
			end
			void'(exp_index.pop_front());
			void'(exp_hit.pop_front());
			void'(exp_rej.pop_front());
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [31:0] ip_addr;
	logic [5:0]  prefix_len;
	logic        exact_mode;
	logic [15:0] route_index;
	logic        strobe;
	logic [15:0] result_index;
	logic        hit;
	logic        rejected;

	route_scoreboard sb;
	int idle_cycles;
	int n_req;

	logic [31:0] pool_addr[8];
	logic [5:0]  pool_len[8];

	longest_prefix_route_table u_top (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && strobe) sb.check_result(result_index, hit, rejected);
		if (arst_n && ((start && !busy) || strobe)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchLimit) begin
			$display("watchdog expired");
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_request(op_t op, logic [31:0] addr, logic [5:0] len,
			logic exact, logic [15:0] port);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		ip_addr <= addr;
		prefix_len <= len;
		exact_mode <= exact;
		route_index <= port;
		do @(posedge clk); while (busy);
		sb.note_request(op, addr, len, exact, port);
		n_req++;
	endtask

	task automatic random_request();
		op_t         op;
		int          k;
		logic [31:0] a;
		logic [5:0]  l;
		logic [15:0] p;
		k = $urandom_range(0, 7);
		l = $urandom_range(0, 9) == 0 ? 6'($urandom) : 6'($urandom_range(0, 32));
		a = $urandom_range(0, 1) ? (pool_addr[k] & sb.lpm_mask(pool_len[k])) : $urandom;
		if ($urandom_range(0, 1)) l = pool_len[k];
		p = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 15));
		op = op_t'($urandom_range(0, 3));
		if (op == OP_INSERT && sb.addr_q.size() > 40 && $urandom_range(0, 3) != 0)
			op = OP_REMOVE;
		if (op == OP_MATCH && $urandom_range(0, 1)) a = pool_addr[k] | 32'($urandom_range(0, 255));
		send_request(op, a, l, 1'($urandom), p);
	endtask

	initial begin
		sb = new();
		idle_cycles = 0;
		n_req = 0;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_INSERT;
		ip_addr = '0;
		prefix_len = '0;
		exact_mode = 1'b0;
		route_index = '0;
		for (int i = 0; i < 8; i++) begin
			pool_addr[i] = $urandom;
			pool_len[i] = 6'($urandom_range(0, 32));
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then extremes
		send_request(OP_MATCH, 32'hFFFF_FFFF, 6'd32, 1'b0, 16'hFFFF);
		send_request(OP_ITERATE, '0, '0, 1'b0, 16'd0);
		send_request(OP_REMOVE, '0, '0, 1'b0, 16'd0);
		send_request(OP_INSERT, 32'h0A00_0000, 6'd8, 1'b0, 16'd1);
		send_request(OP_INSERT, 32'h0A01_0000, 6'd16, 1'b1, 16'd2);
		send_request(OP_INSERT, 32'h0A01_0000, 6'd16, 1'b0, 16'd3);
		send_request(OP_INSERT, 32'h0000_0000, 6'd0, 1'b0, 16'hFFFF);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 6'd63, 1'b0, 16'h8000);
		send_request(OP_INSERT, 32'h0A01_02FF, 6'd24, 1'b0, 16'd4);
		send_request(OP_MATCH, 32'h0A01_0203, 6'd0, 1'b0, 16'd0);
		send_request(OP_MATCH, 32'hFFFF_FFFF, 6'd0, 1'b0, 16'd0);
		send_request(OP_MATCH, 32'h0A01_0000, 6'd16, 1'b1, 16'd0);
		send_request(OP_MATCH, 32'hFFFF_FFFF, 6'd63, 1'b1, 16'd0);
		send_request(OP_ITERATE, '0, '0, 1'b0, 16'd0);
		send_request(OP_ITERATE, '0, '0, 1'b0, 16'd2);
		send_request(OP_ITERATE, '0, '0, 1'b0, 16'hFFFF);
		send_request(OP_ITERATE, '0, '0, 1'b0, 16'd77);
		send_request(OP_REMOVE, 32'h0A01_0000, 6'd16, 1'b0, 16'd0);
		send_request(OP_MATCH, 32'h0A01_0000, 6'd16, 1'b1, 16'd0);
		// fill to full and overflow, then empty the table
		while (sb.addr_q.size() < TableDepth)
			send_request(OP_INSERT, $urandom, 6'($urandom_range(0, 32)), 1'b0,
				16'($urandom));
		send_request(OP_INSERT, 32'h1234_5678, 6'd20, 1'b0, 16'd9);
		send_request(OP_ITERATE, '0, '0, 1'b0, sb.port_q[TableDepth - 1]);
		while (sb.addr_q.size() != 0)
			send_request(OP_REMOVE, sb.addr_q[0], sb.len_q[0], 1'b0, 16'd0);

		repeat (500) random_request();
		start <= 1'b0;

		while (sb.exp_index.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d requests sent, %0d results checked, incl. full-table reject",
			n_req, sb.checked);
		if (sb.errors == 0 && sb.exp_index.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

/* filelist.f */
design/lprt_pkg.sv
design/lprt_cell.sv
design/longest_prefix_route_table.sv
design/lprt_checker.sv
tb/testbench.sv
